### hw/rtl/window_nearest_seed_search_assert.svh
// ----------------------------------------------------------------------------
// window nearest seed search assertion macros
// shared property forms for the port level checker
// ----------------------------------------------------------------------------
`ifndef WINDOW_NEAREST_SEED_SEARCH_ASSERT_SVH
`define WINDOW_NEAREST_SEED_SEARCH_ASSERT_SVH

// condition implies consequence in the same cycle
`define WNSS_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("wnss check failed");

// condition implies consequence in the next cycle
`define WNSS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("wnss check failed");

`endif

### hw/rtl/wnss_pkg.sv
// ----------------------------------------------------------------------------
// wnss_pkg
// constants, types and helpers of the window nearest seed search
// ----------------------------------------------------------------------------
package wnss_pkg;

   localparam int MAX_WIDTH    = 512;
   localparam int MAX_HEIGHT   = 512;
   localparam int LABEL_BITS   = 12;

   localparam int POS_BITS     = 9;
   localparam int ID_BITS      = 12;
   localparam int DIM_BITS     = 10;
   localparam int RADIUS_BITS  = 7;
   localparam int SQ_BITS      = 14;
   localparam int CSR_IDX_BITS = 2;

   localparam int DIST_BOUND   = 10000;
   localparam int RADIUS_RESET = 60;
   localparam int DIM_RESET    = 512;

   localparam int DIST_BITS    = 2 * RADIUS_BITS + 1;
   localparam int X_BITS       = $clog2(MAX_WIDTH);
   localparam int Y_BITS       = $clog2(MAX_HEIGHT);
   localparam int XY_BITS      = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int WORD_BITS    = LABEL_BITS + 1;
   localparam int SPAN_BITS    = POS_BITS + 1;
   localparam int CALC_A       = (XY_BITS > SPAN_BITS) ? XY_BITS : SPAN_BITS;
   localparam int CALC_BITS    = ((CALC_A > DIM_BITS) ? CALC_A : DIM_BITS) + 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_SEARCH_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic                   valid;
      logic [RADIUS_BITS-1:0] dx;
      logic [RADIUS_BITS-1:0] dy;
      logic [POS_BITS-1:0]    x;
      logic [POS_BITS-1:0]    y;
   } cand_type;

   typedef struct packed {
      logic                load;
      logic [POS_BITS-1:0] qx;
      logic [POS_BITS-1:0] qy;
   } query_init_type;

   typedef struct packed {
      logic                  hit;
      logic [DIST_BITS-1:0]  sq_dist;
      logic [POS_BITS-1:0]   x;
      logic [POS_BITS-1:0]   y;
      logic [LABEL_BITS-1:0] label;
   } best_type;

   function automatic logic [ADDR_BITS-1:0] pix_addr(input logic [XY_BITS-1:0] x,
                                                     input logic [XY_BITS-1:0] y);
      return ADDR_BITS'(int'(y) * MAX_WIDTH + int'(x));
   endfunction

endpackage

### hw/rtl/wnss_seed_mem.sv
// ----------------------------------------------------------------------------
// wnss_seed_mem
// seed map store, one word per pixel holding the seed flag and label
// ----------------------------------------------------------------------------
module wnss_seed_mem (
   input  logic                           clock,
   input  wnss_pkg::mem_wr_type           wr,
   input  logic [wnss_pkg::ADDR_BITS-1:0] raddr,
   output logic [wnss_pkg::WORD_BITS-1:0] rdata
);

   logic [wnss_pkg::WORD_BITS-1:0] store_ff [wnss_pkg::STORE_DEPTH];
   logic [wnss_pkg::WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/wnss_dist_unit.sv
// ----------------------------------------------------------------------------
// wnss_dist_unit
// squared distance and best candidate compare, reused for every window pixel
// ----------------------------------------------------------------------------
module wnss_dist_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  wnss_pkg::cand_type             cand,
   input  logic [wnss_pkg::WORD_BITS-1:0] mem_rdata,
   input  wnss_pkg::query_init_type       qinit,
   output wnss_pkg::best_type             best
);

   wnss_pkg::cand_type                    c1_ff;
   logic [2*wnss_pkg::RADIUS_BITS-1:0]    sq_x;
   logic [2*wnss_pkg::RADIUS_BITS-1:0]    sq_y;
   logic [wnss_pkg::DIST_BITS-1:0]        dist_in;
   logic                                  v2_ff;
   logic [wnss_pkg::DIST_BITS-1:0]        d2_ff;
   logic [wnss_pkg::POS_BITS-1:0]         x2_ff;
   logic [wnss_pkg::POS_BITS-1:0]         y2_ff;
   logic [wnss_pkg::LABEL_BITS-1:0]       label2_ff;
   wnss_pkg::best_type                    best_ff;
   wnss_pkg::best_type                    best_in;

   // stage 1 lines up the candidate with the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
      end else begin
         c1_ff <= cand;
      end
   end

   assign sq_x    = c1_ff.dx * c1_ff.dx;
   assign sq_y    = c1_ff.dy * c1_ff.dy;
   assign dist_in = wnss_pkg::DIST_BITS'(sq_x) + wnss_pkg::DIST_BITS'(sq_y);

   // stage 2 holds the distance of a seed pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= c1_ff.valid && mem_rdata[wnss_pkg::WORD_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      d2_ff     <= dist_in;
      x2_ff     <= c1_ff.x;
      y2_ff     <= c1_ff.y;
      label2_ff <= mem_rdata[wnss_pkg::LABEL_BITS-1:0];
   end

   // strict compare keeps the first seed on a tie
   always_comb begin
      best_in = best_ff;
      priority if (qinit.load) begin
         best_in.hit     = 1'b0;
         best_in.sq_dist = wnss_pkg::DIST_BITS'(wnss_pkg::DIST_BOUND);
         best_in.x       = qinit.qx;
         best_in.y       = qinit.qy;
         best_in.label   = '0;
      end else if (v2_ff && (d2_ff < best_ff.sq_dist)) begin
         best_in.hit     = 1'b1;
         best_in.sq_dist = d2_ff;
         best_in.x       = x2_ff;
         best_in.y       = y2_ff;
         best_in.label   = label2_ff;
      end else begin
         best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule

### hw/rtl/wnss_scan_seq.sv
// ----------------------------------------------------------------------------
// wnss_scan_seq
// sequencer for the clearing pass, pixel writes and the window scan
// ----------------------------------------------------------------------------
module wnss_scan_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             req_type,
   input  logic [wnss_pkg::POS_BITS-1:0]    pos_x,
   input  logic [wnss_pkg::POS_BITS-1:0]    pos_y,
   input  logic                             seed_mark,
   input  logic [wnss_pkg::ID_BITS-1:0]     seed_id,
   input  logic [wnss_pkg::CALC_BITS-1:0]   width_eff,
   input  logic [wnss_pkg::CALC_BITS-1:0]   height_eff,
   input  logic [wnss_pkg::RADIUS_BITS-1:0] radius,
   output logic                             busy,
   output logic                             done,
   output wnss_pkg::mem_wr_type             mem_wr,
   output logic [wnss_pkg::ADDR_BITS-1:0]   mem_raddr,
   output wnss_pkg::cand_type               cand,
   output wnss_pkg::query_init_type         qinit
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } seq_state_type;

   seq_state_type                      state_ff, state_in;
   logic [wnss_pkg::ADDR_BITS-1:0]     clr_ff, clr_in;
   logic                               drain_ff, drain_in;
   logic [wnss_pkg::X_BITS-1:0]        x_ff, x_in, x_start_ff, x_start_in, x_end_ff, x_end_in;
   logic [wnss_pkg::Y_BITS-1:0]        y_ff, y_in, y_start_ff, y_start_in, y_end_ff, y_end_in;
   logic [wnss_pkg::POS_BITS-1:0]      qx_ff, qx_in, qy_ff, qy_in;

   logic                               accept;
   logic                               is_query;
   logic                               wr_in_range;
   logic [wnss_pkg::CALC_BITS-1:0]     qx_c, qy_c, r_c;
   logic [wnss_pkg::CALC_BITS-1:0]     x_lo, x_hi, x_clip, y_lo, y_hi, y_clip;
   logic                               x_ok, y_ok;
   logic [wnss_pkg::CALC_BITS-1:0]     cx_c, cy_c, qxs_c, qys_c;

   assign busy     = (state_ff != ST_IDLE);
   assign done     = (state_ff == ST_DONE);
   assign accept   = start && (state_ff == ST_IDLE);
   assign is_query = (wnss_pkg::req_kind_type'(req_type) == wnss_pkg::REQ_QUERY);
   assign wr_in_range = (pos_x < wnss_pkg::MAX_WIDTH) && (pos_y < wnss_pkg::MAX_HEIGHT);

   // window bounds clipped to the image
   assign qx_c   = wnss_pkg::CALC_BITS'(pos_x);
   assign qy_c   = wnss_pkg::CALC_BITS'(pos_y);
   assign r_c    = wnss_pkg::CALC_BITS'(radius);
   assign x_lo   = (qx_c > r_c) ? (qx_c - r_c) : '0;
   assign y_lo   = (qy_c > r_c) ? (qy_c - r_c) : '0;
   assign x_hi   = qx_c + r_c;
   assign y_hi   = qy_c + r_c;
   assign x_clip = (x_hi < width_eff) ? x_hi : (width_eff - wnss_pkg::CALC_BITS'(1));
   assign y_clip = (y_hi < height_eff) ? y_hi : (height_eff - wnss_pkg::CALC_BITS'(1));
   assign x_ok   = (x_lo < width_eff);
   assign y_ok   = (y_lo < height_eff);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      drain_in   = drain_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      x_start_in = x_start_ff;
      x_end_in   = x_end_ff;
      y_start_in = y_start_ff;
      y_end_in   = y_end_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == wnss_pkg::ADDR_BITS'(wnss_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_query) begin
               qx_in      = pos_x;
               qy_in      = pos_y;
               x_start_in = wnss_pkg::X_BITS'(x_lo);
               x_end_in   = wnss_pkg::X_BITS'(x_clip);
               y_start_in = wnss_pkg::Y_BITS'(y_lo);
               y_end_in   = wnss_pkg::Y_BITS'(y_clip);
               x_in       = wnss_pkg::X_BITS'(x_lo);
               y_in       = wnss_pkg::Y_BITS'(y_lo);
               drain_in   = 1'b0;
               state_in   = (x_ok && y_ok) ? ST_SCAN : ST_DRAIN;
            end
         end
         ST_SCAN: begin
            if (y_ff == y_end_ff) begin
               y_in = y_start_ff;
               if (x_ff == x_end_ff) begin
                  drain_in = 1'b0;
                  state_in = ST_DRAIN;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      x_start_ff <= x_start_in;
      x_end_ff   <= x_end_in;
      y_start_ff <= y_start_in;
      y_end_ff   <= y_end_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
   end

   // store writes: clearing pass or a pixel write transfer
   always_comb begin
      mem_wr.en   = (state_ff == ST_CLEAR) || (accept && !is_query && wr_in_range);
      mem_wr.addr = clr_ff;
      mem_wr.data = '0;
      if (state_ff != ST_CLEAR) begin
         mem_wr.addr = wnss_pkg::pix_addr(wnss_pkg::XY_BITS'(pos_x),
                                          wnss_pkg::XY_BITS'(pos_y));
         mem_wr.data = {seed_mark, wnss_pkg::LABEL_BITS'(seed_id)};
      end
   end

   assign mem_raddr = wnss_pkg::pix_addr(wnss_pkg::XY_BITS'(x_ff), wnss_pkg::XY_BITS'(y_ff));

   assign cx_c  = wnss_pkg::CALC_BITS'(x_ff);
   assign cy_c  = wnss_pkg::CALC_BITS'(y_ff);
   assign qxs_c = wnss_pkg::CALC_BITS'(qx_ff);
   assign qys_c = wnss_pkg::CALC_BITS'(qy_ff);

   always_comb begin
      cand.valid = (state_ff == ST_SCAN);
      cand.dx    = wnss_pkg::RADIUS_BITS'((cx_c > qxs_c) ? (cx_c - qxs_c) : (qxs_c - cx_c));
      cand.dy    = wnss_pkg::RADIUS_BITS'((cy_c > qys_c) ? (cy_c - qys_c) : (qys_c - cy_c));
      cand.x     = wnss_pkg::POS_BITS'(x_ff);
      cand.y     = wnss_pkg::POS_BITS'(y_ff);
   end

   always_comb begin
      qinit.load = accept && is_query;
      qinit.qx   = pos_x;
      qinit.qy   = pos_y;
   end

endmodule

### hw/rtl/window_nearest_seed_search.sv
// ----------------------------------------------------------------------------
// window_nearest_seed_search
// seed map with a windowed nearest seed query
//
//   channel    ports                        handshake
//   request    start, busy, req_*           start high while busy low
//   response   rsp_valid, rsp_*             one cycle strobe, no stall
//   registers  csr_wr_en, csr_index, csr_*  write enable, no wait
//
// a pixel write gives no response
// a query reads the store once for each of N pixels, N the window pixels inside the image, up to
// (2 * radius + 1) squared, with one store read per cycle
// after reset a clearing pass over all 262144 store words runs with busy high
// register writes are taken at any time
// ----------------------------------------------------------------------------
module window_nearest_seed_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [wnss_pkg::POS_BITS-1:0]      req_pos_x,
   input  logic [wnss_pkg::POS_BITS-1:0]      req_pos_y,
   input  logic                               req_seed_mark,
   input  logic [wnss_pkg::ID_BITS-1:0]       req_seed_id,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [wnss_pkg::POS_BITS-1:0]      rsp_near_x,
   output logic [wnss_pkg::POS_BITS-1:0]      rsp_near_y,
   output logic [wnss_pkg::ID_BITS-1:0]       rsp_near_label,
   output logic [wnss_pkg::SQ_BITS-1:0]       rsp_sq_dist,
   input  logic                               csr_wr_en,
   input  logic [wnss_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [wnss_pkg::DIM_BITS-1:0]      csr_wdata
);

   logic [wnss_pkg::DIM_BITS-1:0]    image_width_ff, image_width_in;
   logic [wnss_pkg::DIM_BITS-1:0]    image_height_ff, image_height_in;
   logic [wnss_pkg::RADIUS_BITS-1:0] search_radius_ff, search_radius_in;
   logic [wnss_pkg::CALC_BITS-1:0]   width_eff, height_eff;

   wnss_pkg::mem_wr_type             mem_wr;
   logic [wnss_pkg::ADDR_BITS-1:0]   mem_raddr;
   logic [wnss_pkg::WORD_BITS-1:0]   mem_rdata;
   wnss_pkg::cand_type               cand;
   wnss_pkg::query_init_type         qinit;
   wnss_pkg::best_type               best;
   logic                             done;

   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      search_radius_in = search_radius_ff;
      if (csr_wr_en) begin
         unique case (wnss_pkg::csr_index_type'(csr_index))
            wnss_pkg::CSR_IMAGE_WIDTH:   image_width_in   = csr_wdata;
            wnss_pkg::CSR_IMAGE_HEIGHT:  image_height_in  = csr_wdata;
            wnss_pkg::CSR_SEARCH_RADIUS: search_radius_in = csr_wdata[wnss_pkg::RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= wnss_pkg::DIM_BITS'(wnss_pkg::DIM_RESET);
         image_height_ff  <= wnss_pkg::DIM_BITS'(wnss_pkg::DIM_RESET);
         search_radius_ff <= wnss_pkg::RADIUS_BITS'(wnss_pkg::RADIUS_RESET);
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         search_radius_ff <= search_radius_in;
      end
   end

   // image size saturates at the store size
   assign width_eff  = (image_width_ff > wnss_pkg::MAX_WIDTH) ?
                       wnss_pkg::CALC_BITS'(wnss_pkg::MAX_WIDTH) :
                       wnss_pkg::CALC_BITS'(image_width_ff);
   assign height_eff = (image_height_ff > wnss_pkg::MAX_HEIGHT) ?
                       wnss_pkg::CALC_BITS'(wnss_pkg::MAX_HEIGHT) :
                       wnss_pkg::CALC_BITS'(image_height_ff);

   wnss_scan_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .seed_mark  (req_seed_mark),
      .seed_id    (req_seed_id),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .radius     (search_radius_ff),
      .busy       (busy),
      .done       (done),
      .mem_wr     (mem_wr),
      .mem_raddr  (mem_raddr),
      .cand       (cand),
      .qinit      (qinit)
   );

   wnss_seed_mem u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   wnss_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .cand      (cand),
      .mem_rdata (mem_rdata),
      .qinit     (qinit),
      .best      (best)
   );

   assign rsp_valid      = done;
   assign rsp_found      = best.hit;
   assign rsp_near_x     = best.x;
   assign rsp_near_y     = best.y;
   assign rsp_near_label = best.hit ? wnss_pkg::ID_BITS'(best.label) : '0;
   assign rsp_sq_dist    = best.hit ? wnss_pkg::SQ_BITS'(best.sq_dist) : '0;

endmodule

### hw/rtl/wnss_checker.sv
// ----------------------------------------------------------------------------
// wnss_checker
// port level checks of the window nearest seed search
// ----------------------------------------------------------------------------
`include "window_nearest_seed_search_assert.svh"

module wnss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_type,
   input logic                               rsp_valid,
   input logic                               rsp_found,
   input logic [wnss_pkg::ID_BITS-1:0]       rsp_near_label,
   input logic [wnss_pkg::SQ_BITS-1:0]       rsp_sq_dist
);

   logic query_xfer;
   logic write_xfer;

   assign query_xfer = start && !busy && (req_type == wnss_pkg::REQ_QUERY);
   assign write_xfer = start && !busy && (req_type == wnss_pkg::REQ_WRITE);

   `WNSS_ASSERT_NEXT(a_query_goes_busy, clock, reset, query_xfer, busy && !rsp_valid)
   `WNSS_ASSERT_NEXT(a_write_no_rsp, clock, reset, write_xfer, !rsp_valid && !busy)
   `WNSS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy)
   `WNSS_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_found,
                     rsp_near_label == '0 && rsp_sq_dist == '0)
   `WNSS_ASSERT_SAME(a_hit_bound, clock, reset, rsp_valid && rsp_found,
                     rsp_sq_dist < wnss_pkg::SQ_BITS'(wnss_pkg::DIST_BOUND))

endmodule

bind window_nearest_seed_search wnss_checker u_checker (.*);
